// File: rtl/rmtd_pkg.sv
// ----------------------------------------------------------------------------
// rmtd_pkg
// Codes and fixed widths shared by the rail move-to-distance controller.
// ----------------------------------------------------------------------------
package rmtd_pkg;

    localparam int OP_W   = 3;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam int TARGET_W = 23;
    localparam int TOL_W    = 16;
    localparam int TICKS_W  = 24;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE   = 3'd1;
    localparam logic [OP_W-1:0] OP_OBSTACLE = 3'd2;
    localparam logic [OP_W-1:0] OP_START    = 3'd3;
    localparam logic [OP_W-1:0] OP_HALT     = 3'd4;

    localparam logic [CMD_W-1:0] CMD_STOP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BACK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_IDLE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RUNNING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SUCCESS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FAILURE = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOVE_TMO    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OBST_TMO    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STALE_LIMIT = 3'd4;

    localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 16'd50;
    localparam logic [TICKS_W-1:0] STALE_LIMIT_RST = 24'd500;

endpackage

// File: rtl/rail_move_to_distance_controller.sv
// ----------------------------------------------------------------------------
// rail_move_to_distance_controller
// Bang-bang rail position controller driven by tick, sample, obstacle,
// start and halt transactions, with an APB register port.
// ----------------------------------------------------------------------------
// Result: registered in the output register in the cycle after its input.
// Throughput: 1 transaction per cycle; one output register, so input is
//   taken while a result waits if m_tready is high in the same cycle.
// Reset: aresetn synchronous active low; clears move state, counters and
//   output valid, and loads register defaults (tolerance 50, stale limit 500).
// ----------------------------------------------------------------------------
module rail_move_to_distance_controller #(
    parameter int DIST_BITS = 24,
    parameter int TIME_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rmtd_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [rmtd_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [rmtd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata: distance_mm, obstacle_in
    input  logic [((DIST_BITS+1+7)/8)*8-1:0]      s_tdata,
    // tuser: op
    input  logic [rmtd_pkg::OP_W-1:0]             s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata: status, command, command_sent, reached_mm, odom_stale
    output logic [((DIST_BITS+6+7)/8)*8-1:0]      m_tdata
);
    import rmtd_pkg::*;

    localparam int OUT_W = ((DIST_BITS + 6 + 7) / 8) * 8;
    localparam int CW    = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;
    localparam int EW    = ((DIST_BITS > TARGET_W) ? DIST_BITS : TARGET_W) + 2;

    // configuration
    logic [TARGET_W-1:0] target_reg;
    logic [TOL_W-1:0]    tolerance_reg;
    logic [TICKS_W-1:0]  move_tmo_reg;
    logic [TICKS_W-1:0]  obst_tmo_reg;
    logic [TICKS_W-1:0]  stale_limit_reg;

    // move state
    logic                 running_reg, running_next;
    logic                 obst_flag_reg, obst_flag_next;
    logic                 obst_wait_reg, obst_wait_next;
    logic                 seen_reg, seen_next;
    logic [DIST_BITS-1:0] position_reg, position_next;
    logic [TIME_BITS-1:0] age_reg, age_next;
    logic [TIME_BITS-1:0] active_reg, active_next;
    logic [TIME_BITS-1:0] wait_reg, wait_next;
    logic [CMD_W-1:0]     last_sent_reg, last_sent_next;

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic                 wr_en;
    logic                 in_fire;
    logic [OP_W-1:0]      op;
    logic [DIST_BITS-1:0] dist_in;
    logic                 obst_in;

    logic [TIME_BITS-1:0] age_inc, active_inc, wait_inc;
    logic                 stale_tick;
    logic                 stale_out;
    logic signed [EW-1:0] err;
    logic [EW-1:0]        err_mag;
    logic                 in_tol;

    logic [STAT_W-1:0]    status;
    logic [CMD_W-1:0]     cmd;
    logic                 sent;
    logic [DIST_BITS-1:0] reached;
    logic [OUT_W-1:0]     result;

    // ------------------------------------------------------------------ APB
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= '0;
            tolerance_reg   <= TOLERANCE_RST;
            move_tmo_reg    <= '0;
            obst_tmo_reg    <= '0;
            stale_limit_reg <= STALE_LIMIT_RST;
        end else if (wr_en) begin
            unique case (paddr[APB_ADDR_W-1:2])
                REG_TARGET:      target_reg      <= pwdata[TARGET_W-1:0];
                REG_TOLERANCE:   tolerance_reg   <= pwdata[TOL_W-1:0];
                REG_MOVE_TMO:    move_tmo_reg    <= pwdata[TICKS_W-1:0];
                REG_OBST_TMO:    obst_tmo_reg    <= pwdata[TICKS_W-1:0];
                REG_STALE_LIMIT: stale_limit_reg <= pwdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_TARGET:      prdata = APB_DATA_W'(target_reg);
            REG_TOLERANCE:   prdata = APB_DATA_W'(tolerance_reg);
            REG_MOVE_TMO:    prdata = APB_DATA_W'(move_tmo_reg);
            REG_OBST_TMO:    prdata = APB_DATA_W'(obst_tmo_reg);
            REG_STALE_LIMIT: prdata = APB_DATA_W'(stale_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ datapath
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign op       = s_tuser;
    assign dist_in  = s_tdata[DIST_BITS-1:0];
    assign obst_in  = s_tdata[DIST_BITS];

    assign age_inc    = (&age_reg)    ? age_reg    : age_reg + 1'b1;
    assign active_inc = (&active_reg) ? active_reg : active_reg + 1'b1;
    assign wait_inc   = (&wait_reg)   ? wait_reg   : wait_reg + 1'b1;

    assign stale_tick = ~seen_reg | (CW'(age_inc) > CW'(stale_limit_reg));

    assign err     = $signed(EW'(target_reg)) - EW'(signed'(position_reg));
    assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
    assign in_tol  = err_mag <= EW'(tolerance_reg);

    always_comb begin
        running_next   = running_reg;
        obst_flag_next = obst_flag_reg;
        obst_wait_next = obst_wait_reg;
        seen_next      = seen_reg;
        position_next  = position_reg;
        age_next       = age_reg;
        active_next    = active_reg;
        wait_next      = wait_reg;
        last_sent_next = last_sent_reg;

        status  = running_reg ? STAT_RUNNING : STAT_IDLE;
        cmd     = (last_sent_reg == CMD_NONE) ? CMD_STOP : last_sent_reg;
        sent    = 1'b0;
        reached = '0;

        case (op)
            OP_TICK: begin
                age_next = age_inc;
                if (running_reg) begin
                    if (obst_flag_reg) begin
                        obst_wait_next = 1'b1;
                        wait_next      = obst_wait_reg ? wait_inc : '0;
                        cmd            = CMD_STOP;
                        if (obst_tmo_reg != '0 &&
                            CW'(wait_next) >= CW'(obst_tmo_reg)) begin
                            running_next = 1'b0;
                            status       = STAT_FAILURE;
                        end
                    end else begin
                        obst_wait_next = 1'b0;
                        active_next    = active_inc;
                        if (move_tmo_reg != '0 &&
                            CW'(active_inc) >= CW'(move_tmo_reg)) begin
                            cmd          = CMD_STOP;
                            running_next = 1'b0;
                            status       = STAT_FAILURE;
                        end else if (stale_tick) begin
                            cmd = CMD_STOP;
                        end else if (in_tol) begin
                            cmd          = CMD_STOP;
                            reached      = position_reg;
                            running_next = 1'b0;
                            status       = STAT_SUCCESS;
                        end else begin
                            cmd = err[EW-1] ? CMD_BACK : CMD_FWD;
                        end
                    end
                    if (cmd != last_sent_reg) begin
                        last_sent_next = cmd;
                        sent           = 1'b1;
                    end
                end
            end
            OP_SAMPLE: begin
                position_next = dist_in;
                age_next      = '0;
                seen_next     = 1'b1;
            end
            OP_OBSTACLE: begin
                obst_flag_next = obst_in;
            end
            OP_START: begin
                if (tolerance_reg == '0 || stale_limit_reg == '0) begin
                    cmd          = CMD_STOP;
                    running_next = 1'b0;
                    status       = STAT_FAILURE;
                    if (last_sent_reg != CMD_STOP) begin
                        last_sent_next = CMD_STOP;
                        sent           = 1'b1;
                    end
                end else begin
                    running_next   = 1'b1;
                    obst_wait_next = 1'b0;
                    active_next    = '0;
                    wait_next      = '0;
                    last_sent_next = CMD_NONE;
                    cmd            = CMD_STOP;
                    status         = STAT_RUNNING;
                end
            end
            OP_HALT: begin
                cmd          = CMD_STOP;
                running_next = 1'b0;
                status       = STAT_IDLE;
                if (last_sent_reg != CMD_STOP) begin
                    last_sent_next = CMD_STOP;
                    sent           = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign stale_out = ~seen_next | (CW'(age_next) > CW'(stale_limit_reg));
    assign result    = OUT_W'({stale_out, reached, sent, cmd, status});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            obst_flag_reg <= 1'b0;
            obst_wait_reg <= 1'b0;
            seen_reg      <= 1'b0;
            position_reg  <= '0;
            age_reg       <= '0;
            active_reg    <= '0;
            wait_reg      <= '0;
            last_sent_reg <= CMD_NONE;
        end else if (in_fire) begin
            running_reg   <= running_next;
            obst_flag_reg <= obst_flag_next;
            obst_wait_reg <= obst_wait_next;
            seen_reg      <= seen_next;
            position_reg  <= position_next;
            age_reg       <= age_next;
            active_reg    <= active_next;
            wait_reg      <= wait_next;
            last_sent_reg <= last_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rail move-to-distance controller. A directed
// table followed by random move sequences is streamed in under several
// register settings. Every transaction is run through a local model of the
// controller, and each result is checked field by field in arrival order.
// Both streams idle at random.
// ----------------------------------------------------------------------------
module tb;
    import rmtd_pkg::*;

    localparam int DIST_W      = 24;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 110;
    localparam int DIR_ROWS    = 25;
    localparam int MAX_SHOWN   = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;

    // result fields, lowest bits first: status, command, command_sent, reached_mm, odom_stale
    typedef struct packed {
        logic              odom_stale;
        logic [DIST_W-1:0] reached_mm;
        logic              command_sent;
        logic [CMD_W-1:0]  command;
        logic [STAT_W-1:0] status;
    } report_t;

    localparam int REP_W = $bits(report_t);

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DIST_W-1:0] dist_mm;
        logic              obs;
        bit                typed;
        report_t           want;
    } row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;

    rail_move_to_distance_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register shadow
    logic [TARGET_W-1:0] cfg_target    = '0;
    logic [TOL_W-1:0]    cfg_tol       = TOLERANCE_RST;
    logic [TICKS_W-1:0]  cfg_move_tmo  = '0;
    logic [TICKS_W-1:0]  cfg_obst_tmo  = '0;
    logic [TICKS_W-1:0]  cfg_stale_lim = STALE_LIMIT_RST;

    // controller state as the model sees it
    bit                       moving        = 1'b0;
    bit                       obstacle_seen = 1'b0;
    bit                       obstacle_hold = 1'b0;
    bit                       have_sample   = 1'b0;
    logic signed [DIST_W-1:0] rail_sample   = '0;
    logic [TICKS_W-1:0]       sample_age    = '0;
    logic [TICKS_W-1:0]       active_ticks  = '0;
    logic [TICKS_W-1:0]       hold_ticks    = '0;
    logic [CMD_W-1:0]         last_cmd      = CMD_NONE;

    report_t pending_reports[$];

    int  failures     = 0;
    int  items_sent   = 0;
    int  reports_seen = 0;
    int  arrivals     = 0;
    int  aborts       = 0;
    int  motor_sends  = 0;
    bit  src_steady   = 1'b0;
    bit  sink_steady  = 1'b0;

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("ERROR: %s", what);
    endtask

    function automatic logic [TICKS_W-1:0] sat_up(input logic [TICKS_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic bit sample_is_stale();
        return !have_sample || sample_age > cfg_stale_lim;
    endfunction

    function automatic void drive_motor(inout report_t r, input logic [CMD_W-1:0] c);
        r.command = c;
        if (c != last_cmd) begin
            last_cmd = c;
            r.command_sent = 1'b1;
        end
    endfunction

    function automatic report_t predict_report(input logic [OP_W-1:0] op,
                                               input logic [DIST_W-1:0] dist_mm,
                                               input logic obs);
        report_t r;
        longint  err;
        longint  mag;
        r = '0;
        r.command = (last_cmd == CMD_NONE) ? CMD_STOP : last_cmd;
        r.status = moving ? STAT_RUNNING : STAT_IDLE;
        case (op)
            OP_TICK: begin
                sample_age = sat_up(sample_age);
                if (moving) begin
                    if (obstacle_seen) begin
                        if (obstacle_hold) begin
                            hold_ticks = sat_up(hold_ticks);
                        end else begin
                            obstacle_hold = 1'b1;
                            hold_ticks = '0;
                        end
                        drive_motor(r, CMD_STOP);
                        if (cfg_obst_tmo != 0 && hold_ticks >= cfg_obst_tmo) begin
                            moving = 1'b0;
                            r.status = STAT_FAILURE;
                        end
                    end else begin
                        obstacle_hold = 1'b0;
                        active_ticks = sat_up(active_ticks);
                        if (cfg_move_tmo != 0 && active_ticks >= cfg_move_tmo) begin
                            drive_motor(r, CMD_STOP);
                            moving = 1'b0;
                            r.status = STAT_FAILURE;
                        end else if (sample_is_stale()) begin
                            drive_motor(r, CMD_STOP);
                        end else begin
                            err = longint'(cfg_target) - longint'(rail_sample);
                            mag = (err < 0) ? -err : err;
                            if (mag <= longint'(cfg_tol)) begin
                                drive_motor(r, CMD_STOP);
                                r.reached_mm = rail_sample;
                                moving = 1'b0;
                                r.status = STAT_SUCCESS;
                            end else begin
                                drive_motor(r, (err > 0) ? CMD_FWD : CMD_BACK);
                            end
                        end
                    end
                end
            end
            OP_SAMPLE: begin
                rail_sample = dist_mm;
                sample_age = '0;
                have_sample = 1'b1;
            end
            OP_OBSTACLE: obstacle_seen = obs;
            OP_START: begin
                if (cfg_tol == 0 || cfg_stale_lim == 0) begin
                    drive_motor(r, CMD_STOP);
                    moving = 1'b0;
                    r.status = STAT_FAILURE;
                end else begin
                    moving = 1'b1;
                    obstacle_hold = 1'b0;
                    active_ticks = '0;
                    hold_ticks = '0;
                    last_cmd = CMD_NONE;
                    r.command = CMD_STOP;
                    r.status = STAT_RUNNING;
                end
            end
            OP_HALT: begin
                drive_motor(r, CMD_STOP);
                moving = 1'b0;
                r.status = STAT_IDLE;
            end
            default: ;
        endcase
        r.odom_stale = sample_is_stale();
        return r;
    endfunction

    function automatic report_t outcome(input logic [STAT_W-1:0] st, input logic [CMD_W-1:0] c,
                                        input logic sent, input logic stale);
        report_t r;
        r = '0;
        r.status = st;
        r.command = c;
        r.command_sent = sent;
        r.odom_stale = stale;
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DIST_W-1:0] dist_mm,
                             input logic obs, input bit typed, input report_t want);
        int      gap;
        report_t pred;
        gap = src_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // tdata fields, lowest bits first: distance_mm, obstacle_in
        s_tdata  <= {7'b0, obs, dist_mm};
        do @(posedge aclk); while (!s_tready);
        pred = predict_report(op, dist_mm, obs);
        pending_reports.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_TARGET:      cfg_target    = val[TARGET_W-1:0];
            REG_TOLERANCE:   cfg_tol       = val[TOL_W-1:0];
            REG_MOVE_TMO:    cfg_move_tmo  = val[TICKS_W-1:0];
            REG_OBST_TMO:    cfg_obst_tmo  = val[TICKS_W-1:0];
            REG_STALE_LIMIT: cfg_stale_lim = val[TICKS_W-1:0];
            default: ;
        endcase
        case (idx)
            REG_TARGET:    held = 32'(cfg_target);
            REG_TOLERANCE: held = 32'(cfg_tol);
            REG_MOVE_TMO:  held = 32'(cfg_move_tmo);
            REG_OBST_TMO:  held = 32'(cfg_obst_tmo);
            default:       held = 32'(cfg_stale_lim);
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (rd !== held)
            note_failure($sformatf("register %0d reads %h, expected %h", idx, rd, held));
    endtask

    // upper bits carry junk that the registers must drop
    task automatic apply_setting(input int ph);
        logic [31:0] t;
        logic [31:0] tol;
        logic [31:0] mv;
        logic [31:0] ob;
        logic [31:0] st;
        t   = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 20000);
        tol = $urandom_range(1, 300);
        mv  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        ob  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        st  = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 5000) : $urandom_range(1, 25);
        case (ph)
            1: begin
                t = '1; tol = '1; mv = '1; ob = '1; st = '1;
            end
            2: tol = 32'hFFFF_0000;
            3: st = 32'hFF00_0000;
            4: begin
                t = 32'hFF80_0000; tol = 1; mv = 0; ob = 0; st = 1;
            end
            default: ;
        endcase
        if (ph > 1) begin
            t[31:TARGET_W] = (32-TARGET_W)'($urandom);
            if (ph != 2)
                tol[31:TOL_W] = (32-TOL_W)'($urandom);
            mv[31:TICKS_W] = (32-TICKS_W)'($urandom);
            ob[31:TICKS_W] = (32-TICKS_W)'($urandom);
            if (ph != 3)
                st[31:TICKS_W] = (32-TICKS_W)'($urandom);
        end
        reg_write(REG_TARGET, t);
        reg_write(REG_TOLERANCE, tol);
        reg_write(REG_MOVE_TMO, mv);
        reg_write(REG_OBST_TMO, ob);
        reg_write(REG_STALE_LIMIT, st);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (3) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = report_t'(m_tdata[REP_W-1:0]);
            reports_seen++;
            if (got.status == STAT_SUCCESS)
                arrivals++;
            if (got.status == STAT_FAILURE)
                aborts++;
            if (got.command_sent)
                motor_sends++;
            if (pending_reports.size() == 0) begin
                note_failure($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = pending_reports.pop_front();
                if (got.status !== want.status || got.command !== want.command ||
                    got.command_sent !== want.command_sent ||
                    got.reached_mm !== want.reached_mm || got.odom_stale !== want.odom_stale)
                    note_failure($sformatf({"result %0d exp/got: status %0d/%0d cmd %0d/%0d ",
                        "sent %0d/%0d reached %0d/%0d stale %0d/%0d"}, reports_seen,
                        want.status, got.status, want.command, got.command,
                        want.command_sent, got.command_sent, $signed(want.reached_mm),
                        $signed(got.reached_mm), want.odom_stale, got.odom_stale));
            end
        end
    end

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #4_000_000;
        $display("rail_move_to_distance_controller test failed");
        $finish;
    end

    initial begin
        row_t              plan [DIR_ROWS];
        int                ph;
        int                k;
        int                r;
        int                span;
        int                step;
        int                rail_pos;
        logic [OP_W-1:0]   op;
        logic [DIST_W-1:0] dist_mm;
        logic              obs;

        plan = '{
            '{OP_TICK,     24'h000000, 1'b0, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b0, 1'b1)},
            '{OP_HALT,     24'h000000, 1'b0, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b1, 1'b1)},
            '{OP_SAMPLE,   24'h7FFFFF, 1'b1, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b0, 1'b0)},
            '{OP_SAMPLE,   24'h800000, 1'b1, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b0, 1'b0)},
            '{OP_START,    24'hFFFFFF, 1'b1, 1'b1, outcome(STAT_RUNNING, CMD_STOP, 1'b0, 1'b0)},
            '{OP_TICK,     24'hFFFFFF, 1'b1, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_SAMPLE,   24'h7FFFFF, 1'b0, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_OBSTACLE, 24'h000000, 1'b1, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_OBSTACLE, 24'hFFFFFF, 1'b0, 1'b0, '0},
            '{OP_SAMPLE,   24'd30,     1'b0, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_START,    24'h000000, 1'b0, 1'b0, '0},
            '{OP_START,    24'h000000, 1'b0, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_START,    24'h000000, 1'b0, 1'b0, '0},
            '{OP_HALT,     24'h000000, 1'b0, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b1, 1'b0)},
            '{OP_UNUSED_A, 24'h5A5A5A, 1'b1, 1'b0, '0},
            '{OP_UNUSED_B, 24'hA5A5A5, 1'b0, 1'b0, '0},
            '{OP_UNUSED_C, 24'hFFFFFF, 1'b1, 1'b0, '0},
            '{OP_TICK,     24'h000000, 1'b0, 1'b0, '0},
            '{OP_HALT,     24'h000000, 1'b0, 1'b1, outcome(STAT_IDLE, CMD_STOP, 1'b0, 1'b0)}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].op, plan[i].dist_mm, plan[i].obs, plan[i].typed, plan[i].want);
        settle();

        for (ph = 1; ph <= N_PHASES; ph++) begin
            apply_setting(ph);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            span = int'(cfg_tol) * 4 + 400;
            rail_pos = int'(cfg_target);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                dist_mm = DIST_W'($urandom);
                obs = 1'($urandom);
                op = OP_TICK;
                if (r < 5) begin
                    op = OP_START;
                    rail_pos = int'(cfg_target) + int'($urandom_range(0, 2 * span)) - span;
                end else if (r < 7) begin
                    op = OP_HALT;
                end else if (r < 11) begin
                    op = OP_OBSTACLE;
                    obs = ($urandom_range(0, 2) == 0);
                end else if (r < 30) begin
                    op = OP_SAMPLE;
                    step = $urandom_range(0, span / 3);
                    rail_pos = (rail_pos < int'(cfg_target)) ? rail_pos + step : rail_pos - step;
                    if ($urandom_range(0, 9) != 0)
                        dist_mm = rail_pos[DIST_W-1:0];
                end else if (r < 33) begin
                    op = OP_W'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
                end
                send_item(op, dist_mm, obs, 1'b0, '0);
            end
            settle();
        end

        src_steady = 1'b0;
        if (pending_reports.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_reports.size()));

        $display("Streamed %0d transactions (%0d from the directed table) under %0d settings.",
                 items_sent, DIR_ROWS, N_PHASES + 1);
        $display("Moves reached target %0d times and failed %0d times; %0d motor commands sent.",
                 arrivals, aborts, motor_sends);
        if (failures == 0) begin
            $display("rail_move_to_distance_controller test passed");
        end else begin
            $display("rail_move_to_distance_controller test failed");
        end
        $finish;
    end

endmodule
